/* hdl/swbf_pkg.sv */
// Side window box filter: shared constants, types and reciprocal tables.
// Used by swbf_cell and side_window_box_filter_top.
`default_nettype none
package swbf_pkg;

  localparam int MAX_RADIUS = 3;
  localparam int GRID       = 2 * MAX_RADIUS + 1;
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int DIM_W      = 12;
  localparam int PEND_W     = 14;
  localparam int RING_SIZE  = 2 * (MAX_RADIUS * MAX_WIDTH + MAX_RADIUS) + 2;
  localparam int SUM_W      = 14;
  localparam int RCP_W      = 19;
  localparam int RCP_SH     = 20;

  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic OP_PIXEL = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_WR, ST_DEC, ST_BRD, ST_BDAT,
    ST_SUM, ST_COL, ST_DIV, ST_PICK, ST_DONE
  } state_t;

  typedef struct packed {
    logic              rd_en;
    logic              shift;
    logic              sum_en;
    logic [ADDR_W-1:0] addr;
    logic [1:0]        radius;
  } cell_ctl_t;

  typedef struct packed {
    logic [9:0]  left;
    logic [9:0]  right;
    logic [10:0] full;
    logic [7:0]  ctr;
  } row_sums_t;

  // ceil(2^20 / count) for quadrant windows, count (r+1)^2
  function automatic logic [RCP_W-1:0] recip_quad(input logic [1:0] r);
    logic [RCP_W-1:0] v;
    unique case (r)
      2'd2:    v = 19'd116509;
      2'd3:    v = 19'd65536;
      default: v = 19'd262144;
    endcase
    return v;
  endfunction

  // ceil(2^20 / count) for half windows, count (r+1)(2r+1)
  function automatic logic [RCP_W-1:0] recip_half(input logic [1:0] r);
    logic [RCP_W-1:0] v;
    unique case (r)
      2'd2:    v = 19'd69906;
      2'd3:    v = 19'd37450;
      default: v = 19'd174763;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* hdl/swbf_cell.sv */
// One window row: line delay memory, row shift register and row sums.
// Depends on swbf_pkg.
`default_nettype none
module swbf_cell (
  input  wire                    clk,
  input  swbf_pkg::cell_ctl_t    ctl,
  input  wire [7:0]              din,
  output logic [7:0]             rdata,
  output swbf_pkg::row_sums_t    sums
);
  import swbf_pkg::*;

  logic [7:0] mem [MAX_WIDTH];
  logic [7:0] win [GRID];
  row_sums_t  sums_next;

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata <= mem[ctl.addr];
    end
    if (ctl.shift) begin
      mem[ctl.addr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      win[GRID-1] <= din;
      for (int i = 0; i < GRID - 1; i++) begin
        win[i] <= win[i+1];
      end
    end
    if (ctl.sum_en) begin
      sums <= sums_next;
    end
  end

  always_comb begin
    int r;
    int lo;
    int mid;
    r   = int'(ctl.radius);
    lo  = GRID - 1 - 2 * r;
    mid = GRID - 1 - r;
    sums_next = '0;
    for (int i = 0; i < GRID; i++) begin
      if (i >= lo && i <= mid) begin
        sums_next.left = sums_next.left + 10'(win[i]);
      end
      if (i >= mid) begin
        sums_next.right = sums_next.right + 10'(win[i]);
      end
      if (i >= lo) begin
        sums_next.full = sums_next.full + 11'(win[i]);
      end
      if (i == mid) begin
        sums_next.ctr = win[i];
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/side_window_box_filter_top.sv */
// Side window box filter top: control sequencer, chain of row cells,
// window sums, means and side window selection. Depends on swbf_pkg, swbf_cell.
//
//   channel   signals                        direction
//   request   in_valid in_stall opcode pixel_in   in
//   result    out_valid out_stall pixel_out frame_end  out
//   config    wr_en wr_index wr_data         in
//
// Each request runs through the sequencer states in turn; the input stalls
// until the sequencer is idle again. The steps are the registered read of
// the single-port line memories in each cell and the row sum, column sum,
// divide and select stages. Reset: synchronous, clears control, counters
// and out_valid and loads the default configuration; line memories and data
// registers are not cleared. A stalled result holds in the output register;
// the next result waits in the done state with the input stalled.
`default_nettype none
module side_window_box_filter_top (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire        opcode,
  input  wire [7:0]  pixel_in,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [7:0] pixel_out,
  output logic       frame_end,
  input  wire        wr_en,
  input  wire [1:0]  wr_index,
  input  wire [11:0] wr_data
);
  import swbf_pkg::*;

  state_t state, state_next;

  logic [1:0]       radius_reg;
  logic [DIM_W-1:0] width_reg, height_reg;
  logic [1:0]       r;
  logic [DIM_W-1:0] w, h;
  logic [12:0]      delay;

  logic             op_q;
  logic [7:0]       pix_q;
  logic [ADDR_W-1:0] ptr, ptr_last;
  logic [PEND_W-1:0] pending;
  logic [3:0]       pa;
  logic [ADDR_W-1:0] pb;
  logic [ADDR_W-1:0] row, col;

  logic             border, last, emit, ld_out;
  logic [3:0]       ha;
  logic [ADDR_W-1:0] hb;
  logic [DIM_W-1:0] haddr;
  logic [2:0]       sel;

  cell_ctl_t        ctl;
  logic [7:0]       din   [GRID];
  logic [7:0]       rdata [GRID];
  row_sums_t        rs    [GRID];

  logic [SUM_W-1:0] wsum [8];
  logic [SUM_W-1:0] wsum_next [8];
  logic [7:0]       ctr;
  logic [7:0]       mean [8];
  logic [7:0]       mean_next [8];
  logic [7:0]       best_next;
  logic [7:0]       val;

  // effective configuration
  always_comb begin
    r = (radius_reg == 2'd0) ? 2'd1 : radius_reg;
    w = (width_reg == '0) ? 12'd1 :
        (width_reg > 12'(MAX_WIDTH)) ? 12'(MAX_WIDTH) : width_reg;
    h = (height_reg == '0) ? 12'd1 :
        (height_reg > 12'(MAX_HEIGHT)) ? 12'(MAX_HEIGHT) : height_reg;
    delay = 13'(14'(r) * 14'(w) + 14'(r));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_reg <= 2'd1;
      width_reg  <= 12'd640;
      height_reg <= 12'd480;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_RADIUS: radius_reg <= wr_data[1:0];
        REG_WIDTH:  width_reg  <= wr_data;
        REG_HEIGHT: height_reg <= wr_data;
        default: ;
      endcase
    end
  end

  // position of the oldest pending pixel
  always_comb begin
    border = ({1'b0, row} < 12'(r)) || ({1'b0, row} + 12'(r) >= h) ||
             ({1'b0, col} < 12'(r)) || ({1'b0, col} + 12'(r) >= w);
    last   = ({1'b0, row} >= h - 12'd1 && {1'b0, col} >= w - 12'd1) ||
             ({1'b0, row} >= h);
    emit   = (pending > 14'(delay)) || (op_q != OP_PIXEL && border);
    if (pb == '0) begin
      ha = pa - 4'd1;
      hb = ADDR_W'(w - 12'd1);
    end else begin
      ha = pa;
      hb = pb - ADDR_W'(1);
    end
    haddr = {1'b0, ptr_last} - {1'b0, hb};
    if (ptr_last < hb) begin
      haddr = haddr + w;
    end
    sel = (ha > 4'd6) ? 3'd6 : ha[2:0];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (opcode == OP_PIXEL) ? ST_RD : ST_DEC;
        end
      end
      ST_RD:   state_next = ST_WR;
      ST_WR:   state_next = ST_DEC;
      ST_DEC: begin
        if (pending == '0 || !emit) begin
          state_next = ST_IDLE;
        end else if (border) begin
          state_next = ST_BRD;
        end else begin
          state_next = ST_SUM;
        end
      end
      ST_BRD:  state_next = ST_BDAT;
      ST_BDAT: state_next = ST_DONE;
      ST_SUM:  state_next = ST_COL;
      ST_COL:  state_next = ST_DIV;
      ST_DIV:  state_next = ST_PICK;
      ST_PICK: state_next = ST_DONE;
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall   = (state != ST_IDLE);
    ld_out     = (state == ST_DONE) && (!out_valid || !out_stall);
    ctl.rd_en  = (state == ST_RD) || (state == ST_BRD);
    ctl.shift  = (state == ST_WR);
    ctl.sum_en = (state == ST_SUM);
    ctl.addr   = (state == ST_BRD) ? haddr[ADDR_W-1:0] : ptr;
    ctl.radius = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr      <= '0;
      ptr_last <= '0;
      pending  <= '0;
      pa       <= '0;
      pb       <= '0;
      row      <= '0;
      col      <= '0;
    end else begin
      // restart the line rings on a new width
      if (wr_en && wr_index == REG_WIDTH) begin
        ptr <= '0;
      end else if (state == ST_WR) begin
        ptr <= ({1'b0, ptr} >= w - 12'd1) ? '0 : ptr + ADDR_W'(1);
      end
      if (state == ST_WR) begin
        ptr_last <= ptr;
        if (pending < PEND_W'(RING_SIZE)) begin
          pending <= pending + PEND_W'(1);
        end
        if ({1'b0, pb} >= w - 12'd1) begin
          pb <= '0;
          pa <= pa + 4'd1;
        end else begin
          pb <= pb + ADDR_W'(1);
        end
      end
      if (ld_out) begin
        pending <= pending - PEND_W'(1);
        if (pb == '0) begin
          pb <= ADDR_W'(w - 12'd1);
          pa <= pa - 4'd1;
        end else begin
          pb <= pb - ADDR_W'(1);
        end
        if (last) begin
          row <= '0;
          col <= '0;
        end else if ({1'b0, col} >= w - 12'd1) begin
          col <= '0;
          row <= row + ADDR_W'(1);
        end else begin
          col <= col + ADDR_W'(1);
        end
      end
    end
  end

  // chain of row cells
  always_comb begin
    din[0] = pix_q;
    for (int k = 1; k < GRID; k++) begin
      din[k] = rdata[k-1];
    end
  end

  for (genvar k = 0; k < GRID; k++) begin : g_cell
    swbf_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .din   (din[k]),
      .rdata (rdata[k]),
      .sums  (rs[k])
    );
  end

  // window sums over the rows
  always_comb begin
    int ri;
    ri = int'(r);
    for (int s = 0; s < 8; s++) begin
      wsum_next[s] = '0;
    end
    for (int k = 0; k < GRID; k++) begin
      if (k >= ri && k <= 2 * ri) begin
        wsum_next[0] = wsum_next[0] + SUM_W'(rs[k].left);
        wsum_next[1] = wsum_next[1] + SUM_W'(rs[k].right);
        wsum_next[4] = wsum_next[4] + SUM_W'(rs[k].full);
      end
      if (k <= ri) begin
        wsum_next[2] = wsum_next[2] + SUM_W'(rs[k].left);
        wsum_next[3] = wsum_next[3] + SUM_W'(rs[k].right);
        wsum_next[5] = wsum_next[5] + SUM_W'(rs[k].full);
      end
      if (k <= 2 * ri) begin
        wsum_next[6] = wsum_next[6] + SUM_W'(rs[k].right);
        wsum_next[7] = wsum_next[7] + SUM_W'(rs[k].left);
      end
    end
  end

  // means by reciprocal multiply
  always_comb begin
    logic [SUM_W+RCP_W-1:0] prod;
    for (int s = 0; s < 8; s++) begin
      prod = (SUM_W+RCP_W)'(wsum[s]) *
             (SUM_W+RCP_W)'((s < 4) ? recip_quad(r) : recip_half(r));
      mean_next[s] = prod[RCP_SH+7:RCP_SH];
    end
  end

  // first window with the smallest distance to the centre
  always_comb begin
    logic [8:0] bestdiff;
    logic [7:0] d;
    bestdiff  = 9'd256;
    best_next = mean[0];
    for (int s = 0; s < 8; s++) begin
      d = (mean[s] > ctr) ? mean[s] - ctr : ctr - mean[s];
      if ({1'b0, d} < bestdiff) begin
        bestdiff  = {1'b0, d};
        best_next = mean[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      op_q  <= opcode;
      pix_q <= pixel_in;
    end
    if (state == ST_COL) begin
      wsum <= wsum_next;
      ctr  <= rs[{1'b0, r}].ctr;
    end
    if (state == ST_DIV) begin
      mean <= mean_next;
    end
    if (state == ST_PICK) begin
      val <= best_next;
    end
    if (state == ST_BDAT) begin
      val <= rdata[sel];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      pixel_out <= val;
      frame_end <= last;
    end
  end

  a_load_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("result loaded outside done state");

  a_sum_after_dec: assert property (@(posedge clk) disable iff (rst)
    state == ST_SUM |-> $past(state) == ST_DEC)
    else $error("window sums started out of order");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> state != ST_IDLE)
    else $error("request accepted without leaving idle");

endmodule
`default_nettype wire

/* bench/side_window_box_filter_top_tb.sv */
// Self-checking bench for side_window_box_filter_top: directed cases and whole frames
// of random pixels with drain ticks, predicted by a scoreboard class and compared per field.
// Depends on swbf_pkg and side_window_box_filter_top.
`timescale 1ns / 1ps

module side_window_box_filter_top_tb;
  import swbf_pkg::*;

  localparam logic OP_DRAIN = ~OP_PIXEL;
  localparam int   STALL_LIMIT = 5000;

  class filter_scoreboard;
    bit [7:0]    ring [];
    int unsigned wr_ptr, out_pos, pend_cnt;
    int unsigned radius_reg, width_reg, height_reg;
    bit [7:0]    exp_pix [$];
    bit          exp_end [$];
    int          errors;

    function new();
      ring = new[RING_SIZE];
      foreach (ring[i]) ring[i] = 0;
      radius_reg = 1;
      width_reg = 640;
      height_reg = 480;
    endfunction

    function void set_reg(logic [1:0] idx, logic [11:0] val);
      case (idx)
        REG_RADIUS: radius_reg = val[1:0];
        REG_WIDTH:  width_reg = val;
        REG_HEIGHT: height_reg = val;
        default: ;
      endcase
    endfunction

    function int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function bit [7:0] at(int unsigned base, int off);
      int i;
      i = (int'(base) + off) % RING_SIZE;
      if (i < 0) i += RING_SIZE;
      return ring[i];
    endfunction

    function bit [7:0] side_window(int unsigned base, int r, int w);
      int unsigned sum [8];
      int unsigned cnt [8];
      int unsigned p, mean;
      int ctr, d, best, best_d;
      ctr = at(base, 0);
      best = 0;
      best_d = 256;
      foreach (sum[k]) sum[k] = 0;
      for (int dy = -r; dy <= r; dy++)
        for (int dx = -r; dx <= r; dx++) begin
          p = at(base, dy * w + dx);
          if (dy <= 0 && dx <= 0) sum[0] += p;
          if (dy <= 0 && dx >= 0) sum[1] += p;
          if (dy >= 0 && dx <= 0) sum[2] += p;
          if (dy >= 0 && dx >= 0) sum[3] += p;
          if (dy <= 0) sum[4] += p;
          if (dy >= 0) sum[5] += p;
          if (dx >= 0) sum[6] += p;
          if (dx <= 0) sum[7] += p;
        end
      for (int k = 0; k < 8; k++) cnt[k] = k < 4 ? (r + 1) * (r + 1) : (r + 1) * (2 * r + 1);
      for (int k = 0; k < 8; k++) begin
        mean = sum[k] / cnt[k];
        d = int'(mean) > ctr ? int'(mean) - ctr : ctr - int'(mean);
        if (d < best_d) begin
          best_d = d;
          best = k;
        end
      end
      return sum[best] / cnt[best];
    endfunction

    function void note_request(logic op, logic [7:0] pix);
      int unsigned r, w, h, delay, base, row, col;
      bit border, last;
      bit [7:0] val;
      r = clampu(radius_reg, 1, MAX_RADIUS);
      w = clampu(width_reg, 1, MAX_WIDTH);
      h = clampu(height_reg, 1, MAX_HEIGHT);
      delay = r * w + r;
      if (op == OP_PIXEL) begin
        ring[wr_ptr] = pix;
        wr_ptr = (wr_ptr + 1) % RING_SIZE;
        if (pend_cnt < RING_SIZE) pend_cnt++;
      end
      if (pend_cnt == 0) return;
      base = (wr_ptr + RING_SIZE - pend_cnt) % RING_SIZE;
      row = out_pos / w;
      col = out_pos % w;
      border = row < r || row + r >= h || col < r || col + r >= w;
      if (pend_cnt <= delay && (op == OP_PIXEL || !border)) return;
      val = border ? ring[base] : side_window(base, r, w);
      last = out_pos + 1 >= w * h;
      out_pos = last ? 0 : out_pos + 1;
      pend_cnt--;
      exp_pix = {exp_pix, val};
      exp_end = {exp_end, last};
    endfunction

    function void check_result(logic [7:0] pix, logic fe);
      if (exp_pix.size() == 0) begin
        $error("unexpected result pixel_out=%0d frame_end=%0b", pix, fe);
        errors++;
        return;
      end
      if (pix !== exp_pix[0]) begin
        $error("pixel_out expected %0d actual %0d", exp_pix[0], pix);
        errors++;
      end
      if (fe !== exp_end[0]) begin
        $error("frame_end expected %0b actual %0b", exp_end[0], fe);
        errors++;
      end
      void'(exp_pix.pop_front());
      void'(exp_end.pop_front());
    endfunction
  endclass

  logic        clk = 0;
  logic        rst;
  logic        in_valid, in_stall, opcode;
  logic [7:0]  pixel_in;
  logic        out_valid, out_stall, frame_end;
  logic [7:0]  pixel_out;
  logic        wr_en;
  logic [1:0]  wr_index;
  logic [11:0] wr_data;

  filter_scoreboard sb = new();
  int sent_cnt, burst_left, idle_cycles, hold_cnt, stall_mode;
  bit held;

  side_window_box_filter_top u_dut (.*);

  always #2 clk = ~clk;

  initial begin
    rst <= 1;
    in_valid <= 0;
    opcode <= OP_PIXEL;
    pixel_in <= 0;
    out_stall <= 0;
    wr_en <= 0;
    wr_index <= REG_RADIUS;
    wr_data <= 0;
  end

  // receiver: check, then pick next stall from a one-time long hold or a shifting pattern
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_result(pixel_out, frame_end);
      if (!held && sent_cnt >= 150) begin
        held = 1;
        hold_cnt = 300;
      end
      if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1;
      end else
        case (stall_mode)
          0: out_stall <= 0;
          1: out_stall <= $urandom_range(0, 3) == 0;
          default: out_stall <= $urandom_range(0, 3) != 0;
        endcase
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || wr_en || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send(logic op, logic [7:0] pix);
    int gap;
    opcode <= op;
    pixel_in <= pix;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    sb.note_request(op, pix);
    sent_cnt++;
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(0, 30);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain_all();
    while (sb.pend_cnt > 0) send(OP_DRAIN, $urandom_range(0, 255));
    in_valid <= 0;
    @(posedge clk);
    while (sb.exp_pix.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic configure(logic [11:0] r, logic [11:0] w, logic [11:0] h);
    wr_en <= 1;
    wr_index <= REG_RADIUS;
    wr_data <= r;
    @(posedge clk);
    sb.set_reg(REG_RADIUS, r);
    wr_index <= REG_WIDTH;
    wr_data <= w;
    @(posedge clk);
    sb.set_reg(REG_WIDTH, w);
    wr_index <= REG_HEIGHT;
    wr_data <= h;
    @(posedge clk);
    sb.set_reg(REG_HEIGHT, h);
    wr_en <= 0;
    @(posedge clk);
  endtask

  // whole frames with drain ticks mixed in, then empty the tail
  task automatic run_frames(int frames, int drain_pct);
    int n;
    n = frames * sb.clampu(sb.width_reg, 1, MAX_WIDTH) * sb.clampu(sb.height_reg, 1, MAX_HEIGHT);
    for (int i = 0; i < n; i++) begin
      while ($urandom_range(0, 99) < drain_pct) send(OP_DRAIN, $urandom_range(0, 255));
      send(OP_PIXEL, $urandom_range(0, 255));
    end
    drain_all();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    configure(0, 0, 0);
    send(OP_PIXEL, 8'd0);
    send(OP_PIXEL, 8'd255);
    send(OP_DRAIN, 8'd255);
    drain_all();
    configure(1, 5, 5);
    for (int i = 0; i < 25; i++) send(OP_PIXEL, (i % 3 == 0) ? 8'd255 : 8'd0);
    drain_all();
    configure(3, 9, 8);
    run_frames(1, 2);
    while (sent_cnt < 350) begin
      configure($urandom_range(0, 3), $urandom_range(1, 12), $urandom_range(1, 10));
      run_frames(1, $urandom_range(0, 20));
    end
    drain_all();
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.exp_pix.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
